FILE: src/egcd_pkg.sv
// Shared constants, codes and control structs for the extended Euclid gcd block.
// No dependencies; compile first.
`default_nettype none

package egcd_pkg;

    localparam int WIDTH  = 32;            // coefficient width
    localparam int OP_W   = WIDTH - 1;     // operand / gcd width
    localparam int COEF_W = WIDTH;
    localparam int CNT_W  = $clog2(OP_W);  // division bit counter

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EQUAL = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture operands, classify, start first division
        logic step;    // one restoring-division bit
        logic update;  // rotate remainders/coefficients, start next division
        logic emit;    // load the result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_err;    // operands equal or zero (from input payload)
        logic rem_zero;  // last division left no remainder
    } stat_t;

endpackage

`default_nettype wire

FILE: src/egcd_in_if.sv
// Operand channel: valid/ready handshake carrying one operand pair per item.
// Depends on egcd_pkg.
`default_nettype none

interface egcd_in_if;
    import egcd_pkg::*;

    logic            valid;
    logic            ready;
    logic [OP_W-1:0] first_value;
    logic [OP_W-1:0] second_value;

    modport source (output valid, first_value, second_value, input ready);
    modport sink   (input valid, first_value, second_value, output ready);
endinterface

`default_nettype wire

FILE: src/egcd_out_if.sv
// Result channel: valid/ready handshake carrying gcd, coefficients and status.
// Depends on egcd_pkg.
`default_nettype none

interface egcd_out_if;
    import egcd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [OP_W-1:0]          divisor;
    logic signed [COEF_W-1:0] coef_larger;
    logic signed [COEF_W-1:0] coef_smaller;
    logic                     first_was_larger;

    modport source (output valid, status, divisor, coef_larger, coef_smaller,
                    first_was_larger, input ready);
    modport sink   (input valid, status, divisor, coef_larger, coef_smaller,
                    first_was_larger, output ready);
endinterface

`default_nettype wire

FILE: src/egcd_ctrl.sv
// Sequencer for the extended Euclid block: handshakes, bit counter, step order.
// Depends on egcd_pkg.
`default_nettype none

module egcd_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire egcd_pkg::stat_t stat,
    output egcd_pkg::cmd_t      cmd
);
    import egcd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_UPD  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = stat.in_err ? S_FIN : S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(OP_W - 1))
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                if (stat.rem_zero)
                    state_next = S_FIN;
                else
                begin
                    cmd.update = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_FIN:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/egcd_datapath.sv
// Datapath: operand classification, restoring divider with bit-serial
// quotient*coefficient accumulation, Bezout update and result register.
// Depends on egcd_pkg.
`default_nettype none

module egcd_datapath (
    input  wire logic                     clk,
    input  wire logic [egcd_pkg::OP_W-1:0] first_value,
    input  wire logic [egcd_pkg::OP_W-1:0] second_value,
    input  wire egcd_pkg::cmd_t           cmd,
    output egcd_pkg::stat_t               stat,
    output logic [1:0]                    status,
    output logic [egcd_pkg::OP_W-1:0]     divisor,
    output logic signed [egcd_pkg::COEF_W-1:0] coef_larger,
    output logic signed [egcd_pkg::COEF_W-1:0] coef_smaller,
    output logic                          first_was_larger
);
    import egcd_pkg::*;

    // Euclid state; the dividend of each division lives in quo_reg
    logic [OP_W-1:0]   r_cur_reg;
    logic [COEF_W-1:0] x_prev_reg, x_cur_reg, y_prev_reg, y_cur_reg;
    logic [1:0]        st_reg;
    logic              larger_reg;
    // divider
    logic [OP_W-1:0]   quo_reg, rem_reg;
    logic [COEF_W-1:0] px_reg, py_reg;     // q*x_cur, q*y_cur built MSB first
    // result register
    logic [1:0]        res_st_reg;
    logic [OP_W-1:0]   res_d_reg;
    logic [COEF_W-1:0] res_x_reg, res_y_reg;
    logic              res_f_reg;

    logic              eq, zero, first_gt;
    logic [1:0]        st_in;
    logic [OP_W:0]     trial, div_ext, diff;
    logic              ge;
    logic [OP_W-1:0]   rem_next;
    logic [COEF_W-1:0] px_next, py_next;

    assign eq       = (first_value == second_value);
    assign zero     = (first_value == '0) || (second_value == '0);
    assign first_gt = (first_value > second_value);
    assign st_in    = eq ? ST_EQUAL : (zero ? ST_ZERO : ST_OK);

    assign stat.in_err   = eq || zero;
    assign stat.rem_zero = (rem_reg == '0);

    assign trial    = {rem_reg, quo_reg[OP_W-1]};
    assign div_ext  = {1'b0, r_cur_reg};
    assign diff     = trial - div_ext;
    assign ge       = (trial >= div_ext);
    assign rem_next = ge ? diff[OP_W-1:0] : trial[OP_W-1:0];
    assign px_next  = {px_reg[COEF_W-2:0], 1'b0} + (ge ? x_cur_reg : '0);
    assign py_next  = {py_reg[COEF_W-2:0], 1'b0} + (ge ? y_cur_reg : '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            st_reg     <= st_in;
            larger_reg <= first_gt;
            r_cur_reg  <= first_gt ? second_value : first_value;
            quo_reg    <= first_gt ? first_value : second_value;
            rem_reg    <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            x_prev_reg <= COEF_W'(1);
            x_cur_reg  <= '0;
            y_prev_reg <= '0;
            y_cur_reg  <= COEF_W'(1);
        end
        else if (cmd.step)
        begin
            quo_reg <= {quo_reg[OP_W-2:0], 1'b0};
            rem_reg <= rem_next;
            px_reg  <= px_next;
            py_reg  <= py_next;
        end
        else if (cmd.update)
        begin
            r_cur_reg  <= rem_reg;
            x_prev_reg <= x_cur_reg;
            x_cur_reg  <= x_prev_reg - px_reg;
            y_prev_reg <= y_cur_reg;
            y_cur_reg  <= y_prev_reg - py_reg;
            // next division: old divisor over this remainder
            quo_reg    <= r_cur_reg;
            rem_reg    <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
        end

        if (cmd.emit)
        begin
            res_st_reg <= st_reg;
            if (st_reg == ST_OK)
            begin
                res_d_reg <= r_cur_reg;
                res_x_reg <= x_cur_reg;
                res_y_reg <= y_cur_reg;
                res_f_reg <= larger_reg;
            end
            else
            begin
                res_d_reg <= '0;
                res_x_reg <= '0;
                res_y_reg <= '0;
                res_f_reg <= 1'b0;
            end
        end
    end

    assign status           = res_st_reg;
    assign divisor          = res_d_reg;
    assign coef_larger      = res_x_reg;
    assign coef_smaller     = res_y_reg;
    assign first_was_larger = res_f_reg;

endmodule

`default_nettype wire

FILE: src/extended_euclid_gcd_top.sv
// Top level of the extended Euclid gcd block: controller plus datapath.
// Depends on egcd_pkg, egcd_in_if, egcd_out_if, egcd_ctrl, egcd_datapath.
`default_nettype none

// Extended Euclid gcd. Each operand item (two 31-bit unsigned values) yields
// one result item: status (ok / operands equal / operand zero), the gcd and
// the signed 32-bit Bezout coefficients of the larger and smaller operand,
// with coef_larger*larger + coef_smaller*smaller = gcd, plus a flag telling
// whether the first operand was the larger. Equal operands (including two
// zeros) and any zero operand give an error status with all other fields 0.
// When the smaller operand divides the larger, gcd is the smaller operand
// with coefficients 0 and 1. One item is processed at a time: each Euclid
// step runs a restoring divider one quotient bit per cycle, then an update
// step; error items skip the divider. The quotient times coefficient
// products are built bit by bit alongside the division, so no multiplier
// is used. A finished result sits in an output register and the next item
// is accepted while it waits.

module extended_euclid_gcd_top (
    input  wire logic clk,
    input  wire logic rst_n,
    egcd_in_if.sink   operands,
    egcd_out_if.source results
);
    import egcd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: handshakes, division bit count, step order
    egcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_ready  (operands.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // divider, coefficient update and result register
    egcd_datapath u_dp (
        .clk              (clk),
        .first_value      (operands.first_value),
        .second_value     (operands.second_value),
        .cmd              (cmd),
        .stat             (stat),
        .status           (results.status),
        .divisor          (results.divisor),
        .coef_larger      (results.coef_larger),
        .coef_smaller     (results.coef_smaller),
        .first_was_larger (results.first_was_larger)
    );

endmodule

`default_nettype wire

FILE: verif/tb_extended_euclid_gcd_top.sv
// Self-checking testbench for extended_euclid_gcd_top: directed and random operand pairs.
// gcd and Bezout coefficients predicted in SystemVerilog, random stalls on both channels.
// Depends on egcd_pkg, egcd_in_if, egcd_out_if and the block's RTL.
`timescale 1ns / 100ps

module tb_extended_euclid_gcd_top;
    import egcd_pkg::*;

    // Largest legal operand (all OP_W bits set).
    localparam logic [OP_W-1:0] OP_MAX = {OP_W{1'b1}};
    // Bound on the slowest item; used for the tail wait.
    localparam int ITEM_LATENCY = 1600;
    localparam int RANDOM_ITEMS = 400;

    // One expected result item.
    typedef struct {
        logic [1:0]               status;
        logic [OP_W-1:0]          divisor;
        logic signed [COEF_W-1:0] coef_larger;
        logic signed [COEF_W-1:0] coef_smaller;
        logic                     first_was_larger;
    } gcd_result_t;

    logic clk;
    logic rst_n;

    egcd_in_if  operand_ch ();
    egcd_out_if result_ch ();

    extended_euclid_gcd_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operand_ch),
        .results  (result_ch)
    );

    // Results predicted for accepted operand items, oldest first.
    gcd_result_t bezout_expected[$];

    int mismatches  = 0;
    int gap_limit   = 8;   // sender idle gap before each item, drawn from 0..gap_limit
    int stall_limit = 8;   // receiver stall after each result, drawn from 0..stall_limit
    int hold_cycles = 0;   // long receiver hold-off, counted down by the receiver

    // 8 ns clock.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Extended Euclid on the masked operands. Coefficients are carried in 64 bits
    // (wrapping like any unsigned arithmetic) and truncated to COEF_W at the end.
    function automatic gcd_result_t predict_bezout(input logic [OP_W-1:0] u,
                                                   input logic [OP_W-1:0] v);
        gcd_result_t res;
        logic [63:0] r_prev, r_cur, x_prev, x_cur, y_prev, y_cur;
        logic [63:0] quo, rem, x_next, y_next;
        res.status           = ST_OK;
        res.divisor          = '0;
        res.coef_larger      = '0;
        res.coef_smaller     = '0;
        res.first_was_larger = 1'b0;
        // Equality is checked first, so two zeros count as equal.
        if (u == v)
        begin
            res.status = ST_EQUAL;
            return res;
        end
        if (u == '0 || v == '0)
        begin
            res.status = ST_ZERO;
            return res;
        end
        res.first_was_larger = (u > v);
        r_prev = (u > v) ? 64'(u) : 64'(v);
        r_cur  = (u > v) ? 64'(v) : 64'(u);
        x_prev = 64'd1;
        x_cur  = 64'd0;
        y_prev = 64'd0;
        y_cur  = 64'd1;
        quo = r_prev / r_cur;
        rem = r_prev % r_cur;
        // When the smaller divides the larger the loop never runs: gcd is the
        // smaller operand with coefficients 0 and 1.
        while (rem != 64'd0)
        begin
            x_next = x_prev - quo * x_cur;
            y_next = y_prev - quo * y_cur;
            r_prev = r_cur;
            r_cur  = rem;
            x_prev = x_cur;
            x_cur  = x_next;
            y_prev = y_cur;
            y_cur  = y_next;
            quo = r_prev / r_cur;
            rem = r_prev % r_cur;
        end
        res.divisor      = r_cur[OP_W-1:0];
        res.coef_larger  = x_cur[COEF_W-1:0];
        res.coef_smaller = y_cur[COEF_W-1:0];
        return res;
    endfunction

    // Offer one operand item after a random idle gap and wait until it is taken.
    // Valid is left high after acceptance; the next call lowers it only if it idles.
    task automatic offer_operands(input logic [OP_W-1:0] first,
                                  input logic [OP_W-1:0] second);
        int gap;
        gcd_result_t want;
        gap  = $urandom_range(0, gap_limit);
        want = predict_bezout(first, second);
        if (gap > 0)
        begin
            operand_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operand_ch.valid        <= 1'b1;
        operand_ch.first_value  <= first;
        operand_ch.second_value <= second;
        do
            @(posedge clk);
        while (!operand_ch.ready);
        bezout_expected.push_back(want);
    endtask

    // Sender pause: nothing offered until every outstanding result is back.
    task automatic wait_results_drained();
        operand_ch.valid <= 1'b0;
        while (bezout_expected.size() != 0)
            @(posedge clk);
    endtask

    // Compare the result on the channel with the oldest expectation.
    task automatic check_result();
        gcd_result_t want;
        if (bezout_expected.size() == 0)
        begin
            $error("unexpected result item: status %0d divisor %0d", result_ch.status,
                   result_ch.divisor);
            mismatches++;
            return;
        end
        want = bezout_expected.pop_front();
        if (result_ch.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, result_ch.status);
            mismatches++;
        end
        if (result_ch.divisor !== want.divisor)
        begin
            $error("divisor: expected %0d, got %0d", want.divisor, result_ch.divisor);
            mismatches++;
        end
        if (result_ch.coef_larger !== want.coef_larger)
        begin
            $error("coef_larger: expected %0d, got %0d", want.coef_larger,
                   result_ch.coef_larger);
            mismatches++;
        end
        if (result_ch.coef_smaller !== want.coef_smaller)
        begin
            $error("coef_smaller: expected %0d, got %0d", want.coef_smaller,
                   result_ch.coef_smaller);
            mismatches++;
        end
        if (result_ch.first_was_larger !== want.first_was_larger)
        begin
            $error("first_was_larger: expected %0d, got %0d", want.first_was_larger,
                   result_ch.first_was_larger);
            mismatches++;
        end
    endtask

    // Receiver: works cycle by cycle so a hold-off request is seen at once.
    // Ready gets exactly one assignment per edge.
    initial
    begin : result_receiver
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                check_result();
                stall_left = $urandom_range(0, stall_limit);
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Consecutive Fibonacci numbers F(n), F(n+1): the longest Euclid chains.
    function automatic void fibonacci_pair(input int n, output logic [63:0] lo,
                                           output logic [63:0] hi);
        logic [63:0] t;
        lo = 64'd1;
        hi = 64'd1;
        for (int i = 1; i < n; i++)
        begin
            t  = lo + hi;
            lo = hi;
            hi = t;
        end
    endfunction

    // Random operand pair: mostly well-formed pairs of various shapes, some noise.
    function automatic void make_pair(output logic [OP_W-1:0] first,
                                      output logic [OP_W-1:0] second);
        int unsigned pick, w1, w2, g;
        logic [63:0] a, b, k;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            // full-width uniform, covers every bit both ways
            a = 64'($urandom) & 64'(OP_MAX);
            b = 64'($urandom) & 64'(OP_MAX);
        end
        else if (pick < 50)
        begin
            // independent random widths: short and lopsided chains
            w1 = $urandom_range(1, OP_W);
            w2 = $urandom_range(1, OP_W);
            a = 64'($urandom & (OP_MAX >> (OP_W - w1)));
            b = 64'($urandom & (OP_MAX >> (OP_W - w2)));
        end
        else if (pick < 65)
        begin
            // shared factor, gcd above one
            g = $urandom_range(2, 65535);
            a = 64'(g) * $urandom_range(1, OP_MAX / g);
            b = 64'(g) * $urandom_range(1, OP_MAX / g);
        end
        else if (pick < 75)
        begin
            // smaller divides larger
            b = 64'($urandom & (OP_MAX >> (OP_W - $urandom_range(1, 20))));
            if (b == 64'd0)
                b = 64'd1;
            k = $urandom_range(1, OP_MAX / b[31:0]);
            a = b * k;
        end
        else if (pick < 90)
        begin
            // Fibonacci neighbors, optionally scaled
            fibonacci_pair($urandom_range(1, 45), b, a);
            k = $urandom_range(1, OP_MAX / a[31:0]);
            a = a * k;
            b = b * k;
        end
        else
        begin
            // noise: equal operands or a zero operand
            a = 64'($urandom) & 64'(OP_MAX);
            case ($urandom_range(0, 2))
                0:       b = a;
                1:       b = 64'd0;
                default: a = 64'd0;
            endcase
        end
        if ($urandom_range(0, 1) == 1)
        begin
            first  = a[OP_W-1:0];
            second = b[OP_W-1:0];
        end
        else
        begin
            first  = b[OP_W-1:0];
            second = a[OP_W-1:0];
        end
    endfunction

    // Equal operands (two zeros among them) and zero operands.
    task automatic test_error_cases();
        offer_operands('0, '0);
        offer_operands(31'd5, 31'd5);
        offer_operands(OP_MAX, OP_MAX);
        offer_operands('0, 31'd7);
        offer_operands(31'd9, '0);
        offer_operands('0, OP_MAX);
        offer_operands(OP_MAX, '0);
    endtask

    // Smaller operand divides the larger one, in both orders.
    task automatic test_divisible_pairs();
        offer_operands(31'd12, 31'd4);
        offer_operands(31'd4, 31'd12);
        offer_operands(OP_MAX, 31'd1);
        offer_operands(31'd1, OP_MAX);
        offer_operands(31'd2, 31'd1);
    endtask

    // Field extremes, alternating bit patterns and the longest chain.
    task automatic test_extremes();
        logic [63:0] lo, hi;
        fibonacci_pair(45, lo, hi);
        offer_operands(OP_MAX, OP_MAX - 31'd1);
        offer_operands(OP_MAX - 31'd1, OP_MAX);
        offer_operands(hi[OP_W-1:0], lo[OP_W-1:0]);
        offer_operands(lo[OP_W-1:0], hi[OP_W-1:0]);
        offer_operands(31'h2AAA_AAAA, 31'h5555_5555);
        offer_operands(31'h4000_0000, 31'h3FFF_FFFF);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // short items back to back: the output register fills and input stalls.
    task automatic test_backpressure();
        logic [OP_W-1:0] p, q;
        wait_results_drained();
        gap_limit   = 0;
        hold_cycles = 2500;
        for (int i = 0; i < 10; i++)
        begin
            p = OP_W'($urandom_range(1, 4095));
            q = OP_W'($urandom_range(1, 4095));
            offer_operands(p, q);
        end
        gap_limit = 8;
    endtask

    // Long random run; idling comes and goes in stretches, and the sender
    // pauses now and then until every result is back.
    task automatic test_random_pairs();
        logic [OP_W-1:0] p, q;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
            begin
                // every third stretch runs with no idling on either side
                gap_limit   = ((i / 50) % 3 == 2) ? 0 : 8;
                stall_limit = ((i / 50) % 3 == 2) ? 0 : 8;
            end
            if (i % 80 == 79)
                wait_results_drained();
            make_pair(p, q);
            offer_operands(p, q);
        end
        gap_limit   = 8;
        stall_limit = 8;
    endtask

    initial
    begin : stimulus
        // Every input known from time zero.
        rst_n                   <= 1'b0;
        operand_ch.valid        <= 1'b0;
        operand_ch.first_value  <= '0;
        operand_ch.second_value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_error_cases();
        test_divisible_pairs();
        test_extremes();
        test_backpressure();
        test_random_pairs();

        // All items accepted: let the block finish, then watch for strays.
        wait_results_drained();
        repeat (ITEM_LATENCY) @(posedge clk);
        if (mismatches == 0 && bezout_expected.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial
    begin : watchdog
        #30_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
